>>> design/lspc_pkg.sv
`timescale 1ns / 1ps
package lspc_pkg;

   localparam int COORD_W    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PIX_W      = 16;
   localparam int MAT_W      = 32;
   localparam int REG_W      = 64;
   localparam int NEAR_W     = 17;
   localparam int IDX_W      = 3;
   // Camera coordinates stay below 2^48 in magnitude.
   localparam int CAM_W      = 49;
   localparam int DIF_W      = 50;
   localparam int CLIP_W     = 52;
   localparam int MU_W       = FRAC_BITS + 1;
   localparam int NUM_W      = 66;
   localparam int DEN_W      = 50;
   localparam int QUO_W      = 16;
   localparam int DIV_STAGES = QUO_W;

   localparam int NUM_MAT_REGS = 6;
   localparam logic [IDX_W-1:0] REG_NEAR = 3'd6;

   localparam logic [REG_W-1:0] MAT_RESET [NUM_MAT_REGS] = '{
      64'd65536, 64'd0, 64'h0001_0000_0000_0000, 64'd0, 64'd0, 64'd65536
   };
   localparam logic [NEAR_W-1:0] NEAR_RESET = 17'd66;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_z;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic                    visible;
      logic signed [PIX_W-1:0] start_u;
      logic signed [PIX_W-1:0] start_v;
      logic signed [PIX_W-1:0] end_u;
      logic signed [PIX_W-1:0] end_v;
   } rsp_type;

   typedef struct packed {
      logic signed [CAM_W-1:0] a0;
      logic signed [CAM_W-1:0] a1;
      logic signed [CAM_W-1:0] a2;
      logic signed [CAM_W-1:0] b0;
      logic signed [CAM_W-1:0] b1;
      logic signed [CAM_W-1:0] b2;
      logic signed [DIF_W-1:0] dx;
      logic signed [DIF_W-1:0] dy;
      logic                    vis1;
      logic                    vis2;
      logic                    ge;
   } geo_type;

   typedef struct packed {
      logic       visible;
      logic [3:0] ovf;
      logic [3:0] neg;
   } fin_type;

   function automatic logic [MAT_W-1:0] mag32(input logic signed [MAT_W-1:0] v);
      return v[MAT_W-1] ? MAT_W'(-v) : MAT_W'(v);
   endfunction

   // Saturates a truncated quotient magnitude to a signed pixel coordinate.
   function automatic logic [PIX_W-1:0] pix_sat(input logic neg, input logic ovf,
                                                input logic [QUO_W-1:0] q);
      logic [QUO_W-1:0] lim;
      lim = QUO_W'((1 << (PIX_W - 1)) - 1);
      if (neg) begin
         if (ovf || q > lim + QUO_W'(1)) return {1'b1, {(PIX_W-1){1'b0}}};
         return PIX_W'(-q);
      end
      if (ovf || q > lim) return {1'b0, {(PIX_W-1){1'b1}}};
      return PIX_W'(q);
   endfunction

endpackage

>>> design/lspc_div.sv
`timescale 1ns / 1ps
module lspc_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic [lspc_pkg::NUM_W-1:0]     num,
   input  logic [lspc_pkg::DEN_W-1:0]     den,
   output logic [lspc_pkg::QUO_W-1:0]     quot
);

   // One quotient bit per stage, most significant first. The caller
   // guarantees num < den * 2^QUO_W.
   logic [lspc_pkg::NUM_W-1:0] rem_ff [lspc_pkg::DIV_STAGES];
   logic [lspc_pkg::DEN_W-1:0] den_ff [lspc_pkg::DIV_STAGES];
   logic [lspc_pkg::QUO_W-1:0] q_ff   [lspc_pkg::DIV_STAGES];
   logic [lspc_pkg::NUM_W-1:0] rem_src [lspc_pkg::DIV_STAGES];
   logic [lspc_pkg::DEN_W-1:0] den_src [lspc_pkg::DIV_STAGES];
   logic [lspc_pkg::QUO_W-1:0] q_src   [lspc_pkg::DIV_STAGES];

   assign rem_src[0] = num;
   assign den_src[0] = den;
   assign q_src[0]   = '0;

   for (genvar k = 0; k < lspc_pkg::DIV_STAGES; k++) begin : g_stage
      localparam int SH = lspc_pkg::QUO_W - 1 - k;
      logic [lspc_pkg::NUM_W-1:0] den_sh;
      logic                       take;
      logic [lspc_pkg::NUM_W-1:0] rem_in;
      logic [lspc_pkg::QUO_W-1:0] q_in;

      if (k > 0) begin : g_link
         assign rem_src[k] = rem_ff[k-1];
         assign den_src[k] = den_ff[k-1];
         assign q_src[k]   = q_ff[k-1];
      end

      always_comb begin
         den_sh = lspc_pkg::NUM_W'(den_src[k]) << SH;
         take   = rem_src[k] >= den_sh;
         rem_in = take ? rem_src[k] - den_sh : rem_src[k];
         q_in   = q_src[k] | (lspc_pkg::QUO_W'(take) << SH);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src[k];
            q_ff[k]   <= q_in;
         end
      end
   end

   assign quot = q_ff[lspc_pkg::DIV_STAGES-1];

endmodule

>>> design/line_segment_project_clip.sv
`timescale 1ns / 1ps
// Projects one 3D segment per clock, unless stalled, through a configured 3x4
// Q16.16 matrix, clips it against the near plane and returns truncated,
// saturated pixel coordinates. A new word is taken every cycle while the result
// is not stalled. The result passes through 40 register stages, mostly two
// 16-stage restoring dividers in series (clip fraction, then the depth divides).
// A stalled result freezes the whole pipeline. Write the matrix and near limit
// only while no word is in flight.
module line_segment_project_clip (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lspc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lspc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [lspc_pkg::IDX_W-1:0]          csr_index,
   input  logic [lspc_pkg::REG_W-1:0]          csr_wdata
);

   localparam int CW = lspc_pkg::CAM_W;
   localparam int DW = lspc_pkg::DIF_W;
   localparam int LW = lspc_pkg::CLIP_W;
   localparam int FB = lspc_pkg::FRAC_BITS;
   localparam int ND = lspc_pkg::DIV_STAGES;

   logic en;

   // configuration
   logic [lspc_pkg::REG_W-1:0]  reg_ff [lspc_pkg::NUM_MAT_REGS];
   logic [lspc_pkg::NEAR_W-1:0] near_ff;
   logic signed [lspc_pkg::MAT_W-1:0] mat [3][4];
   logic [lspc_pkg::NEAR_W-1:0] near_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lspc_pkg::NUM_MAT_REGS; i++) reg_ff[i] <= lspc_pkg::MAT_RESET[i];
         near_ff <= lspc_pkg::NEAR_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == lspc_pkg::REG_NEAR) begin
            near_ff <= csr_wdata[lspc_pkg::NEAR_W-1:0];
         end else if (csr_index < lspc_pkg::IDX_W'(lspc_pkg::NUM_MAT_REGS)) begin
            reg_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            mat[r][c] = reg_ff[r*2 + (c >> 1)][(c & 1)*32 +: 32];
         end
      end
      near_eff = (near_ff == '0) ? lspc_pkg::NEAR_W'(1) : near_ff;
   end

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // stage 1: input register
   lspc_pkg::req_type pin_ff;
   logic v1_ff;
   logic signed [lspc_pkg::COORD_W-1:0] pt [2][3];

   always_ff @(posedge clock) begin
      if (en) pin_ff <= req_data;
   end

   always_comb begin
      pt[0][0] = pin_ff.start_x;
      pt[0][1] = pin_ff.start_y;
      pt[0][2] = pin_ff.start_z;
      pt[1][0] = pin_ff.end_x;
      pt[1][1] = pin_ff.end_y;
      pt[1][2] = pin_ff.end_z;
   end

   // stage 2: magnitude products
   logic [63:0] prod_ff [2][3][3];
   logic        psgn_ff [2][3][3];
   logic        v2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int e = 0; e < 2; e++) begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  prod_ff[e][r][c] <= 64'(lspc_pkg::mag32(mat[r][c]))
                                      * 64'(lspc_pkg::mag32(pt[e][c]));
                  psgn_ff[e][r][c] <= mat[r][c][31] ^ pt[e][c][31];
               end
            end
         end
      end
   end

   // stage 3: camera coordinates
   logic signed [CW-1:0] cam_ff [2][3];
   logic signed [CW-1:0] cam_in [2][3];
   logic v3_ff;

   always_comb begin
      logic signed [CW+1:0] acc;
      logic signed [CW+1:0] term;
      for (int e = 0; e < 2; e++) begin
         for (int r = 0; r < 3; r++) begin
            acc = (CW+2)'(mat[r][3]);
            for (int c = 0; c < 3; c++) begin
               term = (CW+2)'(prod_ff[e][r][c][63:FB]);
               acc  = psgn_ff[e][r][c] ? acc - term : acc + term;
            end
            cam_in[e][r] = acc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) cam_ff <= cam_in;
   end

   // stage 4: visibility and clip fraction operands
   lspc_pkg::geo_type g4_ff, g4_in;
   logic [lspc_pkg::NUM_W-1:0] mu_num_ff, mu_num_in;
   logic [lspc_pkg::DEN_W-1:0] mu_den_ff, mu_den_in;
   logic v4_ff;

   always_comb begin
      logic signed [CW-1:0] nv;
      logic signed [DW-1:0] nd, zd;
      logic [DW-1:0] n, dd;
      nv = CW'(near_eff);
      g4_in.a0 = cam_ff[0][0];
      g4_in.a1 = cam_ff[0][1];
      g4_in.a2 = cam_ff[0][2];
      g4_in.b0 = cam_ff[1][0];
      g4_in.b1 = cam_ff[1][1];
      g4_in.b2 = cam_ff[1][2];
      g4_in.dx = DW'(cam_ff[1][0]) - DW'(cam_ff[0][0]);
      g4_in.dy = DW'(cam_ff[1][1]) - DW'(cam_ff[0][1]);
      g4_in.vis1 = cam_ff[0][2] > nv;
      g4_in.vis2 = cam_ff[1][2] > nv;
      nd = DW'(nv) - DW'(cam_ff[0][2]);
      zd = DW'(cam_ff[1][2]) - DW'(cam_ff[0][2]);
      n  = nd[DW-1] ? DW'(-nd) : DW'(nd);
      dd = zd[DW-1] ? DW'(-zd) : DW'(zd);
      g4_in.ge  = n >= dd;
      mu_num_in = lspc_pkg::NUM_W'(n) << FB;
      mu_den_in = dd;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g4_ff     <= g4_in;
         mu_num_ff <= mu_num_in;
         mu_den_ff <= mu_den_in;
      end
   end

   // clip fraction divider with matching delay line
   logic [lspc_pkg::QUO_W-1:0] mu_q;
   lspc_pkg::geo_type gd_ff [ND];
   logic vd_ff [ND];

   lspc_div u_mu_div (
      .clock (clock),
      .en    (en),
      .num   (mu_num_ff),
      .den   (mu_den_ff),
      .quot  (mu_q)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         gd_ff[0] <= g4_ff;
         for (int i = 1; i < ND; i++) gd_ff[i] <= gd_ff[i-1];
      end
   end

   // stage 5: partial products of mu times the segment delta
   lspc_pkg::geo_type g5_ff;
   logic [48:0] plo_ff [2];
   logic [34:0] phi_ff [2];
   logic        pneg_ff [2];
   logic [48:0] plo_in [2];
   logic [34:0] phi_in [2];
   logic        pneg_in [2];
   logic v5_ff;

   always_comb begin
      logic [lspc_pkg::MU_W-1:0] mu;
      logic [DW-1:0] dm;
      logic signed [DW-1:0] dv [2];
      mu = gd_ff[ND-1].ge ? lspc_pkg::MU_W'(1 << FB) : lspc_pkg::MU_W'(mu_q);
      dv[0] = gd_ff[ND-1].dx;
      dv[1] = gd_ff[ND-1].dy;
      for (int i = 0; i < 2; i++) begin
         dm         = dv[i][DW-1] ? DW'(-dv[i]) : DW'(dv[i]);
         plo_in[i]  = 49'(mu) * 49'(dm[31:0]);
         phi_in[i]  = 35'(mu) * 35'(dm[DW-1:32]);
         pneg_in[i] = dv[i][DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         pneg_ff <= pneg_in;
         g5_ff   <= gd_ff[ND-1];
      end
   end

   // stage 6: clipped point
   lspc_pkg::geo_type g6_ff;
   logic signed [LW-1:0] cx_ff [2];
   logic signed [LW-1:0] cx_in [2];
   logic v6_ff;

   always_comb begin
      logic [66:0] full;
      logic signed [LW-1:0] term;
      logic signed [CW-1:0] base;
      for (int i = 0; i < 2; i++) begin
         full = (67'(phi_ff[i]) << 32) + 67'(plo_ff[i]);
         term = LW'(full[66:FB]);
         base = (i == 0) ? g5_ff.a0 : g5_ff.a1;
         cx_in[i] = LW'(base) + (pneg_ff[i] ? -term : term);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= cx_in;
         g6_ff <= g5_ff;
      end
   end

   // stage 7: operand select for the four depth divides
   logic [lspc_pkg::NUM_W-1:0] pnum_ff [4], pnum_in [4];
   logic [lspc_pkg::DEN_W-1:0] pden_ff [4], pden_in [4];
   lspc_pkg::fin_type f7_ff, f7_in;
   logic v7_ff;

   always_comb begin
      logic signed [LW-1:0] x [4];
      logic [LW-1:0] xm;
      logic [lspc_pkg::DEN_W-1:0] nden;
      nden = lspc_pkg::DEN_W'(near_eff);
      x[0] = g6_ff.vis1 ? LW'(g6_ff.a0) : cx_ff[0];
      x[1] = g6_ff.vis1 ? LW'(g6_ff.a1) : cx_ff[1];
      x[2] = g6_ff.vis2 ? LW'(g6_ff.b0) : cx_ff[0];
      x[3] = g6_ff.vis2 ? LW'(g6_ff.b1) : cx_ff[1];
      pden_in[0] = g6_ff.vis1 ? lspc_pkg::DEN_W'(g6_ff.a2) : nden;
      pden_in[1] = pden_in[0];
      pden_in[2] = g6_ff.vis2 ? lspc_pkg::DEN_W'(g6_ff.b2) : nden;
      pden_in[3] = pden_in[2];
      f7_in.visible = g6_ff.vis1 || g6_ff.vis2;
      for (int i = 0; i < 4; i++) begin
         xm = x[i][LW-1] ? LW'(-x[i]) : LW'(x[i]);
         pnum_in[i]   = lspc_pkg::NUM_W'(xm);
         f7_in.neg[i] = x[i][LW-1];
         f7_in.ovf[i] = pnum_in[i] >= (lspc_pkg::NUM_W'(pden_in[i]) << FB);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pnum_ff <= pnum_in;
         pden_ff <= pden_in;
         f7_ff   <= f7_in;
      end
   end

   // depth dividers
   logic [lspc_pkg::QUO_W-1:0] pq [4];
   lspc_pkg::fin_type fd_ff [ND];
   logic vf_ff [ND];

   for (genvar i = 0; i < 4; i++) begin : g_pix_div
      lspc_div u_div (
         .clock (clock),
         .en    (en),
         .num   (pnum_ff[i]),
         .den   (pden_ff[i]),
         .quot  (pq[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fd_ff[0] <= f7_ff;
         for (int i = 1; i < ND; i++) fd_ff[i] <= fd_ff[i-1];
      end
   end

   // output register
   lspc_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;

   always_comb begin
      lspc_pkg::fin_type f;
      f = fd_ff[ND-1];
      rsp_in = '0;
      if (f.visible) begin
         rsp_in.visible = 1'b1;
         rsp_in.start_u = lspc_pkg::pix_sat(f.neg[0], f.ovf[0], pq[0]);
         rsp_in.start_v = lspc_pkg::pix_sat(f.neg[1], f.ovf[1], pq[1]);
         rsp_in.end_u   = lspc_pkg::pix_sat(f.neg[2], f.ovf[2], pq[2]);
         rsp_in.end_v   = lspc_pkg::pix_sat(f.neg[3], f.ovf[3], pq[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ND; i++) begin
            vd_ff[i] <= 1'b0;
            vf_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vd_ff[0] <= v4_ff;
         for (int i = 1; i < ND; i++) vd_ff[i] <= vd_ff[i-1];
         v5_ff <= vd_ff[ND-1];
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         vf_ff[0] <= v7_ff;
         for (int i = 1; i < ND; i++) vf_ff[i] <= vf_ff[i-1];
         rsp_valid_ff <= vf_ff[ND-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
